[rtl/core/rcuf_pkg.sv]
// Shared constants, store entry layout and engine control types for the stone component counter.
package rcuf_pkg;

    // Coordinate range and stone capacity.
    localparam int COORDS     = 1024;
    localparam int MAX_STONES = 1024;

    // Field widths of the stone and result transactions.
    localparam int COORD_W = 10;
    localparam int REM_W   = 10;
    localparam int CNT_W   = 11;

    // Row nodes sit below COORDS, column nodes at COORDS plus the column.
    localparam int NODE_COUNT = 2 * COORDS;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int SIZE_W     = $clog2(NODE_COUNT) + 1;

    // One word of the disjoint-set store.
    typedef struct packed {
        logic              used;
        logic [SIZE_W-1:0] size;
        logic [NODE_W-1:0] parent;
    } node_entry_t;

    // Commands from the top level to the union-find engine.
    typedef struct packed {
        logic              start;
        logic              clear;
        logic [NODE_W-1:0] row_node;
        logic [NODE_W-1:0] col_node;
    } eng_cmd_t;

    // Status from the union-find engine back to the top level.
    typedef struct packed {
        logic       idle;
        logic       done;
        logic [1:0] new_nodes;
        logic       merged;
    } eng_sts_t;

endpackage

[rtl/core/rcuf_stone_if.sv]
// Valid/ready channel carrying one stone per transaction.
interface rcuf_stone_if;
    logic                        valid;
    logic                        ready;
    logic [rcuf_pkg::COORD_W-1:0] stone_row;
    logic [rcuf_pkg::COORD_W-1:0] stone_col;
    logic                        last_stone;

    modport source (output valid, stone_row, stone_col, last_stone, input ready);
    modport sink   (input valid, stone_row, stone_col, last_stone, output ready);
endinterface

[rtl/core/rcuf_result_if.sv]
// Valid/ready channel carrying one result per transaction.
interface rcuf_result_if;
    logic                        valid;
    logic                        ready;
    logic [rcuf_pkg::REM_W-1:0]  removable;
    logic [rcuf_pkg::CNT_W-1:0]  components;
    logic                        set_done;
    logic                        overflow;

    modport source (output valid, removable, components, set_done, overflow, input ready);
    modport sink   (input valid, removable, components, set_done, overflow, output ready);
endinterface

[rtl/core/rcuf_engine.sv]
// Union-find engine: disjoint-set store, root search with path compression and union by size.
module rcuf_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  rcuf_pkg::eng_cmd_t cmd,
    output rcuf_pkg::eng_sts_t sts
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEEK,
        ST_LOOK,
        ST_COMP,
        ST_MERGE_SMALL,
        ST_MERGE_LARGE,
        ST_DONE
    } state_t;

    // Store: one word per node, written and read in clocked logic.
    rcuf_pkg::node_entry_t mem [rcuf_pkg::NODE_COUNT];
    rcuf_pkg::node_entry_t rd_data_reg;

    state_t                          state_reg, state_next;
    logic                            side_reg, side_next;
    logic                            first_reg, first_next;
    logic [rcuf_pkg::NODE_W-1:0]     start_reg, start_next;
    logic [rcuf_pkg::NODE_W-1:0]     cur_reg, cur_next;
    logic [rcuf_pkg::NODE_W-1:0]     col_node_reg, col_node_next;
    logic [rcuf_pkg::NODE_W-1:0]     root_reg, root_next;
    logic [rcuf_pkg::SIZE_W-1:0]     size_reg, size_next;
    logic [rcuf_pkg::NODE_W-1:0]     root_a_reg, root_a_next;
    logic [rcuf_pkg::SIZE_W-1:0]     size_a_reg, size_a_next;
    logic [1:0]                      new_nodes_reg, new_nodes_next;
    logic                            merged_reg, merged_next;
    logic [rcuf_pkg::NODE_W-1:0]     clr_idx_reg, clr_idx_next;

    logic [rcuf_pkg::NODE_W-1:0]     rd_addr;
    logic                            mem_we;
    logic [rcuf_pkg::NODE_W-1:0]     wr_addr;
    rcuf_pkg::node_entry_t           wr_data;

    logic                            find_end;
    logic [rcuf_pkg::NODE_W-1:0]     found_root;
    logic [rcuf_pkg::SIZE_W-1:0]     found_size;
    logic                            small_is_a;
    logic [rcuf_pkg::NODE_W-1:0]     small_root;
    logic [rcuf_pkg::NODE_W-1:0]     large_root;
    logic [rcuf_pkg::SIZE_W-1:0]     small_size;

    // The smaller set goes under the larger; a tie puts the column root under the row root.
    assign small_is_a = (size_a_reg < size_reg);
    assign small_root = small_is_a ? root_a_reg : root_reg;
    assign large_root = small_is_a ? root_reg : root_a_reg;
    assign small_size = small_is_a ? size_a_reg : size_reg;

    // Sequencer: store port control and next values.
    always_comb
    begin
        state_next     = state_reg;
        side_next      = side_reg;
        first_next     = first_reg;
        start_next     = start_reg;
        cur_next       = cur_reg;
        col_node_next  = col_node_reg;
        root_next      = root_reg;
        size_next      = size_reg;
        root_a_next    = root_a_reg;
        size_a_next    = size_a_reg;
        new_nodes_next = new_nodes_reg;
        merged_next    = merged_reg;
        clr_idx_next   = clr_idx_reg;
        rd_addr        = cur_reg;
        mem_we         = 1'b0;
        wr_addr        = cur_reg;
        wr_data        = rd_data_reg;
        find_end       = 1'b0;
        found_root     = root_reg;
        found_size     = size_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we         = 1'b1;
                wr_addr        = clr_idx_reg;
                wr_data.used   = 1'b0;
                wr_data.size   = rcuf_pkg::SIZE_W'(1);
                wr_data.parent = clr_idx_reg;
                clr_idx_next   = clr_idx_reg + 1'b1;
                if (clr_idx_reg == rcuf_pkg::NODE_W'(rcuf_pkg::NODE_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (cmd.clear)
                begin
                    clr_idx_next = '0;
                    state_next   = ST_CLEAR;
                end
                else if (cmd.start)
                begin
                    side_next      = 1'b0;
                    first_next     = 1'b1;
                    start_next     = cmd.row_node;
                    cur_next       = cmd.row_node;
                    col_node_next  = cmd.col_node;
                    new_nodes_next = 2'd0;
                    merged_next    = 1'b0;
                    state_next     = ST_SEEK;
                end
            end

            ST_SEEK:
            begin
                rd_addr    = cur_reg;
                state_next = ST_LOOK;
            end

            // Walk up the parent chain one node per cycle.
            ST_LOOK:
            begin
                first_next = 1'b0;
                if (rd_data_reg.parent == cur_reg)
                begin
                    // A node never used before is its own root; mark it now.
                    if (first_reg && !rd_data_reg.used)
                    begin
                        mem_we         = 1'b1;
                        wr_addr        = cur_reg;
                        wr_data.used   = 1'b1;
                        new_nodes_next = new_nodes_reg + 2'd1;
                    end
                    root_next = cur_reg;
                    size_next = rd_data_reg.size;
                    if (start_reg != cur_reg)
                    begin
                        cur_next   = start_reg;
                        rd_addr    = start_reg;
                        state_next = ST_COMP;
                    end
                    else
                    begin
                        find_end   = 1'b1;
                        found_root = cur_reg;
                        found_size = rd_data_reg.size;
                    end
                end
                else
                begin
                    cur_next = rd_data_reg.parent;
                    rd_addr  = rd_data_reg.parent;
                end
            end

            // Second walk: point every node on the path straight at the root.
            ST_COMP:
            begin
                mem_we         = 1'b1;
                wr_addr        = cur_reg;
                wr_data.parent = root_reg;
                if (rd_data_reg.parent == root_reg)
                begin
                    find_end = 1'b1;
                end
                else
                begin
                    cur_next = rd_data_reg.parent;
                    rd_addr  = rd_data_reg.parent;
                end
            end

            ST_MERGE_SMALL:
            begin
                mem_we         = 1'b1;
                wr_addr        = small_root;
                wr_data.used   = 1'b1;
                wr_data.size   = small_size;
                wr_data.parent = large_root;
                state_next     = ST_MERGE_LARGE;
            end

            ST_MERGE_LARGE:
            begin
                mem_we         = 1'b1;
                wr_addr        = large_root;
                wr_data.used   = 1'b1;
                wr_data.size   = size_a_reg + size_reg;
                wr_data.parent = large_root;
                merged_next    = 1'b1;
                state_next     = ST_DONE;
            end

            ST_DONE:
            begin
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // End of a root search: either start on the column node or decide the union.
        if (find_end)
        begin
            if (!side_reg)
            begin
                root_a_next = found_root;
                size_a_next = found_size;
                side_next   = 1'b1;
                first_next  = 1'b1;
                start_next  = col_node_reg;
                cur_next    = col_node_reg;
                state_next  = ST_SEEK;
            end
            else
            begin
                root_next = found_root;
                size_next = found_size;
                if (found_root == root_a_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MERGE_SMALL;
                end
            end
        end
    end

    // Store ports.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            side_reg      <= 1'b0;
            first_reg     <= 1'b0;
            start_reg     <= '0;
            cur_reg       <= '0;
            col_node_reg  <= '0;
            root_reg      <= '0;
            size_reg      <= '0;
            root_a_reg    <= '0;
            size_a_reg    <= '0;
            new_nodes_reg <= 2'd0;
            merged_reg    <= 1'b0;
            clr_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            side_reg      <= side_next;
            first_reg     <= first_next;
            start_reg     <= start_next;
            cur_reg       <= cur_next;
            col_node_reg  <= col_node_next;
            root_reg      <= root_next;
            size_reg      <= size_next;
            root_a_reg    <= root_a_next;
            size_a_reg    <= size_a_next;
            new_nodes_reg <= new_nodes_next;
            merged_reg    <= merged_next;
            clr_idx_reg   <= clr_idx_next;
        end
    end

    assign sts.idle      = (state_reg == ST_IDLE);
    assign sts.done      = (state_reg == ST_DONE);
    assign sts.new_nodes = new_nodes_reg;
    assign sts.merged    = merged_reg;

    // The store is never written while waiting for a command.
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("store written while idle");

    // Compression never rewrites the root itself.
    a_comp_not_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP) |-> (cur_reg != root_reg))
        else $error("compression reached the root");

    // A union only ever joins two distinct roots.
    a_merge_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE_SMALL) |-> (root_reg != root_a_reg))
        else $error("union of a set with itself");

    // Completion is followed directly by the idle state.
    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sts.done |=> sts.idle)
        else $error("engine did not return to idle after completion");

endmodule

[rtl/core/row_col_union_find_components_top.sv]
// Top level of the stone component counter: channels, counters and result register.
//
// Each stone transaction on the stone channel carries a row and a column. The row
// node and the column node are joined in a shared disjoint-set store (union by size,
// path compression), and one result transaction follows per stone: removable
// (stones so far minus components), components, set_done (echo of last_stone) and
// overflow (the stone was ignored because the capacity was already reached).
// Each step up either parent chain costs one read on the way up and one rewrite in
// the compression pass; a stone whose nodes are already joined skips the union
// writes. The store has one read and one write port. Unless a clear follows, the next
// stone can be taken in the cycle after the result is loaded. An ignored stone goes
// straight to the output register without the engine. One stone is in work at a
// time. After reset, and after the result of a stone with last_stone set, the store
// is cleared one node per cycle over all 2048 nodes, and ready stays low meanwhile.
// A finished result waits in the output register; the next stone is accepted
// meanwhile, and only its own result waits for the receiver to take the previous one.
module row_col_union_find_components_top (
    input  logic          clk,
    input  logic          rst_n,
    rcuf_stone_if.sink    stone,
    rcuf_result_if.source result
);

    typedef enum logic [1:0] {
        T_IDLE,
        T_WORK,
        T_OUT
    } tstate_t;

    tstate_t                     tstate_reg, tstate_next;
    logic [rcuf_pkg::CNT_W-1:0]  stones_reg, stones_next;
    logic [rcuf_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                        last_reg, last_next;
    logic                        ovf_reg, ovf_next;
    logic                        out_valid_reg, out_valid_next;
    logic [rcuf_pkg::REM_W-1:0]  out_removable_reg, out_removable_next;
    logic [rcuf_pkg::CNT_W-1:0]  out_components_reg, out_components_next;
    logic                        out_done_reg, out_done_next;
    logic                        out_ovf_reg, out_ovf_next;

    rcuf_pkg::eng_cmd_t          cmd;
    rcuf_pkg::eng_sts_t          sts;
    logic                        accept;
    logic                        full;

    rcuf_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts)
    );

    assign stone.ready = (tstate_reg == T_IDLE) && sts.idle;
    assign accept      = stone.valid && stone.ready;
    assign full        = (stones_reg >= rcuf_pkg::CNT_W'(rcuf_pkg::MAX_STONES));

    // Control of the stone transaction, the counters and the result register.
    always_comb
    begin
        tstate_next         = tstate_reg;
        stones_next         = stones_reg;
        count_next          = count_reg;
        last_next           = last_reg;
        ovf_next            = ovf_reg;
        out_valid_next      = out_valid_reg;
        out_removable_next  = out_removable_reg;
        out_components_next = out_components_reg;
        out_done_next       = out_done_reg;
        out_ovf_next        = out_ovf_reg;
        cmd.start           = 1'b0;
        cmd.clear           = 1'b0;

        // Node numbers for the engine.
        cmd.row_node = rcuf_pkg::NODE_W'(stone.stone_row % rcuf_pkg::COORDS);
        cmd.col_node = rcuf_pkg::NODE_W'(rcuf_pkg::COORDS)
                     + rcuf_pkg::NODE_W'(stone.stone_col % rcuf_pkg::COORDS);

        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (tstate_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    last_next = stone.last_stone;
                    if (full)
                    begin
                        ovf_next    = 1'b1;
                        tstate_next = T_OUT;
                    end
                    else
                    begin
                        ovf_next    = 1'b0;
                        stones_next = stones_reg + 1'b1;
                        cmd.start   = 1'b1;
                        tstate_next = T_WORK;
                    end
                end
            end

            T_WORK:
            begin
                if (sts.done)
                begin
                    count_next = count_reg + rcuf_pkg::CNT_W'(sts.new_nodes)
                               - rcuf_pkg::CNT_W'(sts.merged);
                    tstate_next = T_OUT;
                end
            end

            // Load the result once the register is free; a last stone clears the set.
            T_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next      = 1'b1;
                    out_removable_next  = rcuf_pkg::REM_W'(stones_reg - count_reg);
                    out_components_next = count_reg;
                    out_done_next       = last_reg;
                    out_ovf_next        = ovf_reg;
                    if (last_reg)
                    begin
                        cmd.clear   = 1'b1;
                        stones_next = '0;
                        count_next  = '0;
                    end
                    tstate_next = T_IDLE;
                end
            end

            default:
            begin
                tstate_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tstate_reg         <= T_IDLE;
            stones_reg         <= '0;
            count_reg          <= '0;
            last_reg           <= 1'b0;
            ovf_reg            <= 1'b0;
            out_valid_reg      <= 1'b0;
            out_removable_reg  <= '0;
            out_components_reg <= '0;
            out_done_reg       <= 1'b0;
            out_ovf_reg        <= 1'b0;
        end
        else
        begin
            tstate_reg         <= tstate_next;
            stones_reg         <= stones_next;
            count_reg          <= count_next;
            last_reg           <= last_next;
            ovf_reg            <= ovf_next;
            out_valid_reg      <= out_valid_next;
            out_removable_reg  <= out_removable_next;
            out_components_reg <= out_components_next;
            out_done_reg       <= out_done_next;
            out_ovf_reg        <= out_ovf_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.removable  = out_removable_reg;
    assign result.components = out_components_reg;
    assign result.set_done   = out_done_reg;
    assign result.overflow   = out_ovf_reg;

    // Every component holds at least one stone.
    a_count_le_stones: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= stones_reg)
        else $error("more components than stones");

    // The stone counter never passes the capacity.
    a_stones_cap: assert property (@(posedge clk) disable iff (!rst_n)
        stones_reg <= rcuf_pkg::CNT_W'(rcuf_pkg::MAX_STONES))
        else $error("stone count beyond capacity");

    // While a stone is in work the engine is busy.
    a_work_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (tstate_reg == T_WORK) |-> !sts.idle)
        else $error("waiting on an idle engine");

endmodule

[tb/tb.sv]
// Self-checking testbench for the stone component counter against a union-find predictor.
module tb;

    typedef struct packed {
        logic [rcuf_pkg::COORD_W-1:0] row;
        logic [rcuf_pkg::COORD_W-1:0] col;
        logic                         last_stone;
    } stone_t;

    typedef struct packed {
        logic [rcuf_pkg::REM_W-1:0] removable;
        logic [rcuf_pkg::CNT_W-1:0] components;
        logic                       set_done;
        logic                       overflow;
    } counts_t;

    logic clk = 1'b0;
    logic rst_n;

    rcuf_stone_if  stone ();
    rcuf_result_if result ();

    row_col_union_find_components_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stone  (stone),
        .result (result)
    );

    // Clock with a period of four units.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predictor state: a private copy of the disjoint-set store and its counters.
    logic [rcuf_pkg::NODE_W-1:0] link     [rcuf_pkg::NODE_COUNT];
    logic [rcuf_pkg::SIZE_W-1:0] weight   [rcuf_pkg::NODE_COUNT];
    bit                          occupied [rcuf_pkg::NODE_COUNT];
    int unsigned                 stone_tally;
    int unsigned                 group_tally;

    stone_t  pending_stones [$];
    counts_t due_counts [$];
    int      accepted;
    int      total_stones;
    int      faults;

    function automatic void clear_store();
        for (int n = 0; n < rcuf_pkg::NODE_COUNT; n++)
        begin
            link[n]     = rcuf_pkg::NODE_W'(n);
            weight[n]   = rcuf_pkg::SIZE_W'(1);
            occupied[n] = 1'b0;
        end
        stone_tally = 0;
        group_tally = 0;
    endfunction

    // Root lookup with full path compression.
    function automatic int unsigned find_root(int unsigned x);
        int unsigned r;
        int unsigned nx;
        r = x;
        while (link[r] != r)
            r = 32'(link[r]);
        while (x != r)
        begin
            nx      = 32'(link[x]);
            link[x] = rcuf_pkg::NODE_W'(r);
            x       = nx;
        end
        return r;
    endfunction

    // A node seen for the first time opens a component of its own.
    function automatic void claim_node(int unsigned n);
        if (!occupied[n])
        begin
            occupied[n] = 1'b1;
            group_tally++;
        end
    endfunction

    // Places one stone and returns the counts that the block should report for it.
    function automatic counts_t place_stone(stone_t s);
        int unsigned rn;
        int unsigned cn;
        int unsigned ra;
        int unsigned rb;
        counts_t     res;
        res.overflow = 1'b0;
        if (stone_tally >= rcuf_pkg::MAX_STONES)
            res.overflow = 1'b1;
        else
        begin
            rn = s.row % rcuf_pkg::COORDS;
            cn = rcuf_pkg::COORDS + (s.col % rcuf_pkg::COORDS);
            stone_tally++;
            claim_node(rn);
            claim_node(cn);
            ra = find_root(rn);
            rb = find_root(cn);
            if (ra != rb)
            begin
                // Union by size: the smaller tree hangs under the larger one.
                if (weight[ra] < weight[rb])
                begin
                    link[ra]   = rcuf_pkg::NODE_W'(rb);
                    weight[rb] = weight[rb] + weight[ra];
                end
                else
                begin
                    link[rb]   = rcuf_pkg::NODE_W'(ra);
                    weight[ra] = weight[ra] + weight[rb];
                end
                group_tally--;
            end
        end
        res.removable  = rcuf_pkg::REM_W'(stone_tally - group_tally);
        res.components = rcuf_pkg::CNT_W'(group_tally);
        res.set_done   = s.last_stone;
        if (s.last_stone)
            clear_store();
        return res;
    endfunction

    task automatic add_stone(logic [rcuf_pkg::COORD_W-1:0] r,
                             logic [rcuf_pkg::COORD_W-1:0] c, logic l);
        stone_t s;
        s.row        = r;
        s.col        = c;
        s.last_stone = l;
        pending_stones.insert(pending_stones.size(), s);
    endtask

    // Coordinates lean towards the two ends of the range now and then.
    function automatic logic [rcuf_pkg::COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return rcuf_pkg::COORD_W'($urandom);
        endcase
    endfunction

    // A set drawn from a small pool of rows and columns, so that stones share lines and merge.
    task automatic add_cluster_set(int count);
        logic [rcuf_pkg::COORD_W-1:0] row_pool [$];
        logic [rcuf_pkg::COORD_W-1:0] col_pool [$];
        logic [rcuf_pkg::COORD_W-1:0] r;
        logic [rcuf_pkg::COORD_W-1:0] c;
        int                           pool_n;
        pool_n = $urandom_range(1, 12);
        for (int k = 0; k < pool_n; k++)
        begin
            row_pool.insert(row_pool.size(), pick_coord());
            col_pool.insert(col_pool.size(), pick_coord());
        end
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                r = rcuf_pkg::COORD_W'($urandom);
                c = rcuf_pkg::COORD_W'($urandom);
            end
            else
            begin
                r = row_pool[$urandom_range(0, pool_n - 1)];
                c = col_pool[$urandom_range(0, pool_n - 1)];
            end
            add_stone(r, c, k == count - 1);
        end
    endtask

    // Fills the store to capacity with disjoint stones, then sends stones that must be ignored;
    // the last flag lands on an ignored stone.
    task automatic add_overflow_set();
        int shift;
        int extra;
        shift = $urandom_range(0, rcuf_pkg::COORDS - 1);
        extra = $urandom_range(1, 5);
        for (int k = 0; k < rcuf_pkg::MAX_STONES; k++)
            add_stone(rcuf_pkg::COORD_W'(k),
                      rcuf_pkg::COORD_W'((k + shift) % rcuf_pkg::COORDS), 1'b0);
        for (int k = 0; k < extra; k++)
            add_stone(rcuf_pkg::COORD_W'($urandom), rcuf_pkg::COORD_W'($urandom),
                      k == extra - 1);
    endtask

    // Sender: bursts of stone transactions separated by random gaps.
    stone_t offered;
    int     burst_left;
    int     idle_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stone.valid      <= 1'b0;
            stone.stone_row  <= '0;
            stone.stone_col  <= '0;
            stone.last_stone <= 1'b0;
            burst_left = 0;
            idle_left  = 0;
        end
        else
        begin
            if (stone.valid && stone.ready)
            begin
                due_counts.insert(due_counts.size(), place_stone(offered));
                accepted++;
            end
            if (stone.valid && !stone.ready)
            begin
                // The offered stone stays on the channel until it is taken.
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                stone.valid <= 1'b0;
            end
            else if (pending_stones.size() > 0)
            begin
                offered = pending_stones.pop_front();
                stone.stone_row  <= offered.row;
                stone.stone_col  <= offered.col;
                stone.last_stone <= offered.last_stone;
                stone.valid      <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 48);
                    idle_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            else
                stone.valid <= 1'b0;
        end
    end

    // Receiver: ready follows a random 32-bit pattern, redrawn each time the phase wraps.
    logic [31:0] stall_word;
    int          stall_phase;

    always @(posedge clk or negedge rst_n)
    begin
        counts_t want;
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            stall_phase = 0;
            stall_word  = '1;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (due_counts.size() == 0)
                begin
                    $error("result transaction with no stone outstanding: %0d %0d",
                           result.removable, result.components);
                    faults++;
                end
                else
                begin
                    want = due_counts.pop_front();
                    if (result.removable !== want.removable)
                    begin
                        $error("removable: expected %0d, got %0d",
                               want.removable, result.removable);
                        faults++;
                    end
                    if (result.components !== want.components)
                    begin
                        $error("components: expected %0d, got %0d",
                               want.components, result.components);
                        faults++;
                    end
                    if (result.set_done !== want.set_done)
                    begin
                        $error("set_done: expected %0d, got %0d",
                               want.set_done, result.set_done);
                        faults++;
                    end
                    if (result.overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0d, got %0d",
                               want.overflow, result.overflow);
                        faults++;
                    end
                end
            end
            if (stall_phase == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_word = '1;
                    1:       stall_word = $urandom;
                    2:       stall_word = $urandom | $urandom;
                    default: stall_word = $urandom & $urandom;
                endcase
            end
            result.ready <= stall_word[stall_phase];
            stall_phase = (stall_phase + 1) % 32;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int budget;
        int set_len;
        int overflow_at;
        int queued_n;
        bit overflow_sent;

        rst_n    = 1'b0;
        accepted = 0;
        faults   = 0;
        clear_store();

        // Corners of the grid, a merge of two components, a stone already joined and a repeat.
        add_stone('0, '0, 1'b0);
        add_stone('1, '1, 1'b0);
        add_stone('0, '1, 1'b0);
        add_stone('1, '0, 1'b0);
        add_stone('0, '0, 1'b0);
        add_stone(rcuf_pkg::COORD_W'(512), rcuf_pkg::COORD_W'(511), 1'b1);

        // A set of a single stone.
        add_stone(rcuf_pkg::COORD_W'(341), rcuf_pkg::COORD_W'(682), 1'b1);

        // A staircase that grows one long component, closed by a stone that adds a new column to its first row.
        for (int k = 1; k <= 5; k++)
        begin
            add_stone(rcuf_pkg::COORD_W'(k), rcuf_pkg::COORD_W'(k), 1'b0);
            add_stone(rcuf_pkg::COORD_W'(k + 1), rcuf_pkg::COORD_W'(k), 1'b0);
        end
        add_stone(rcuf_pkg::COORD_W'(1), rcuf_pkg::COORD_W'(6), 1'b1);

        // Random sets, mostly small, with one set that runs past capacity.
        budget        = 0;
        overflow_sent = 1'b0;
        overflow_at   = $urandom_range(0, 40);
        while (budget < 1080)
        begin
            if (!overflow_sent && budget >= overflow_at)
            begin
                queued_n = pending_stones.size();
                add_overflow_set();
                budget += pending_stones.size() - queued_n;
                overflow_sent = 1'b1;
            end
            case ($urandom_range(0, 19))
                0:       set_len = $urandom_range(41, 120);
                1, 2, 3, 4, 5:
                         set_len = $urandom_range(13, 40);
                default: set_len = $urandom_range(1, 12);
            endcase
            add_cluster_set(set_len);
            budget += set_len;
        end
        total_stones = pending_stones.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted != total_stones)
            @(posedge clk);
        while (due_counts.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (faults == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #8000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[row_col_union_find_components_top.f]
rtl/core/rcuf_pkg.sv
rtl/core/rcuf_stone_if.sv
rtl/core/rcuf_result_if.sv
rtl/core/rcuf_engine.sv
rtl/core/row_col_union_find_components_top.sv
tb/tb.sv
